[rtl/dual_bank_parameter_store_defines.svh]
// Assertion macros shared by the parameter store RTL
`ifndef DUAL_BANK_PARAMETER_STORE_DEFINES_SVH
`define DUAL_BANK_PARAMETER_STORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DBPS_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define DBPS_ASSERT_NXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/dbps_pkg.sv]
// Constants, codes, types and helpers of the dual-bank parameter store
`default_nettype none
package dbps_pkg;

   localparam int PAGE_WORDS   = 256;
   localparam int SYSTEM_WORDS = 16;
   localparam int DATA_WORDS   = PAGE_WORDS - 1;
   localparam int USER_WORDS   = (DATA_WORDS > SYSTEM_WORDS) ? (DATA_WORDS - SYSTEM_WORDS) : 0;
   localparam int WORD_AW      = $clog2(PAGE_WORDS);
   localparam int MEM_DEPTH    = 2 * PAGE_WORDS;
   localparam int MEM_AW       = $clog2(MEM_DEPTH);
   localparam int IDX_CW       = ((WORD_AW > 8) ? WORD_AW : 8) + 1;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_READ  = 2'd0;
   localparam cmd_type CMD_WRITE = 2'd1;
   localparam cmd_type CMD_CLEAR = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type STAT_DONE    = 2'd0;
   localparam status_type STAT_SKIPPED = 2'd1;
   localparam status_type STAT_RANGE   = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_LOOK,
      ST_COPY,
      ST_DONE
   } state_type;

   // Memory address of a word within a bank
   function automatic logic [MEM_AW-1:0] bank_addr(input logic bank,
                                                  input logic [WORD_AW-1:0] word);
      logic [MEM_AW-1:0] base;
      base = bank ? MEM_AW'(PAGE_WORDS) : '0;
      return base + MEM_AW'(word);
   endfunction

   // Current bank: larger generation plus one, signed with wrap; tie gives bank 1
   function automatic logic newer_bank(input logic [31:0] gen0, input logic [31:0] gen1);
      logic [31:0] a;
      logic [31:0] b;
      a = (gen0 + 32'd1) ^ 32'h8000_0000;
      b = (gen1 + 32'd1) ^ 32'h8000_0000;
      return (a > b) ? 1'b0 : 1'b1;
   endfunction

endpackage
`default_nettype wire

[rtl/dbps_if.sv]
// Request and response channel interfaces of the parameter store
`default_nettype none
interface dbps_req_if;
   logic                valid;
   logic                ready;
   dbps_pkg::cmd_type   command;
   logic [7:0]          word_index;
   logic signed [31:0]  write_value;

   modport source (output valid, command, word_index, write_value, input ready);
   modport sink   (input valid, command, word_index, write_value, output ready);
endinterface

interface dbps_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [31:0]   read_value;
   dbps_pkg::status_type status;
   logic                 current_bank;

   modport source (output valid, read_value, status, current_bank, input ready);
   modport sink   (input valid, read_value, status, current_bank, output ready);
endinterface
`default_nettype wire

[rtl/dual_bank_parameter_store.sv]
// Top level of the dual-bank parameter store: sequencer, bank memory and response register
//
//   channel   direction  payload                                  handshake
//   req_ch    in         command, word_index, write_value         valid/ready
//   rsp_ch    out        read_value, status, current_bank         valid/ready
//
// After reset a clearing pass sets all 2*PAGE_WORDS memory words to ones, one a cycle;
// no request is taken meanwhile.
// A read, or a write of an unchanged value, passes through the fetch and look states to
// the final state; an out-of-range or unused command goes straight there. A changed write
// follows the look state with a bank copy, and a clear starts one at once; the copy uses
// the single memory port pair, one word a cycle. One request is in flight at a time.
// The response register lets a new request be taken while a response waits; a stalled
// response holds the sequencer in its final state.
`default_nettype none
`include "dual_bank_parameter_store_defines.svh"
module dual_bank_parameter_store (
   input  wire logic clock,
   input  wire logic reset,
   dbps_req_if.sink  req_ch,
   dbps_rsp_if.source rsp_ch
);

   localparam int WORD_AW = dbps_pkg::WORD_AW;
   localparam int MEM_AW  = dbps_pkg::MEM_AW;
   localparam int IDX_CW  = dbps_pkg::IDX_CW;

   // Bank memory: words 0..PAGE_WORDS-1 first bank, the rest second bank
   logic [31:0] mem [dbps_pkg::MEM_DEPTH];
   logic [31:0] rd_q_ff;

   dbps_pkg::state_type  state_ff, state_in;
   dbps_pkg::cmd_type    cmd_ff;
   logic [WORD_AW-1:0]   idx_ff;
   logic [31:0]          val_ff;
   logic                 cur_ff;
   logic [WORD_AW-1:0]   ptr_ff;
   logic [MEM_AW-1:0]    clr_ptr_ff;
   // Generation words kept in flops so the current bank is known at once
   logic [31:0]          gen0_ff, gen1_ff;
   logic [31:0]          res_value_ff, res_value_in;
   dbps_pkg::status_type res_status_ff, res_status_in;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_value_ff;
   dbps_pkg::status_type rsp_status_ff;
   logic                 rsp_bank_ff;

   logic                 cur_bank;
   logic [IDX_CW-1:0]    idx_ext;
   logic                 in_range;
   logic                 accept;
   logic                 copy_last;
   logic                 rsp_load;
   logic                 res_load;
   logic [WORD_AW-1:0]   wr_word;
   logic                 mem_we;
   logic [MEM_AW-1:0]    mem_waddr;
   logic [MEM_AW-1:0]    mem_raddr;
   logic [31:0]          mem_wdata;

   assign cur_bank  = dbps_pkg::newer_bank(gen0_ff, gen1_ff);
   assign idx_ext   = IDX_CW'(req_ch.word_index);
   assign in_range  = idx_ext < IDX_CW'(dbps_pkg::DATA_WORDS);
   assign req_ch.ready = (state_ff == dbps_pkg::ST_IDLE);
   assign accept    = req_ch.valid && req_ch.ready;
   assign copy_last = (state_ff == dbps_pkg::ST_COPY) &&
                      (ptr_ff == WORD_AW'(dbps_pkg::DATA_WORDS));
   assign rsp_load  = (state_ff == dbps_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign wr_word   = ptr_ff - 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dbps_pkg::ST_CLEAR: begin
            if (clr_ptr_ff == MEM_AW'(dbps_pkg::MEM_DEPTH - 1)) state_in = dbps_pkg::ST_IDLE;
         end
         dbps_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_ch.command) inside
                  dbps_pkg::CMD_READ, dbps_pkg::CMD_WRITE: begin
                     state_in = in_range ? dbps_pkg::ST_FETCH : dbps_pkg::ST_DONE;
                  end
                  dbps_pkg::CMD_CLEAR: state_in = dbps_pkg::ST_COPY;
                  default:             state_in = dbps_pkg::ST_DONE;
               endcase
            end
         end
         dbps_pkg::ST_FETCH: state_in = dbps_pkg::ST_LOOK;
         dbps_pkg::ST_LOOK: begin
            if (cmd_ff == dbps_pkg::CMD_WRITE && rd_q_ff != val_ff) state_in = dbps_pkg::ST_COPY;
            else state_in = dbps_pkg::ST_DONE;
         end
         dbps_pkg::ST_COPY: begin
            if (copy_last) state_in = dbps_pkg::ST_DONE;
         end
         dbps_pkg::ST_DONE: begin
            if (rsp_load) state_in = dbps_pkg::ST_IDLE;
         end
         default: state_in = dbps_pkg::ST_CLEAR;
      endcase
   end

   // Memory control and result capture
   always_comb begin
      mem_we        = 1'b0;
      mem_waddr     = dbps_pkg::bank_addr(!cur_ff, wr_word);
      mem_wdata     = rd_q_ff;
      mem_raddr     = dbps_pkg::bank_addr(cur_ff, idx_ff);
      res_load      = 1'b0;
      res_value_in  = '0;
      res_status_in = dbps_pkg::STAT_DONE;
      unique case (state_ff)
         dbps_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ptr_ff;
            mem_wdata = '1;
         end
         dbps_pkg::ST_IDLE: begin
            if (accept) begin
               res_load = 1'b1;
               if ((req_ch.command == dbps_pkg::CMD_READ ||
                    req_ch.command == dbps_pkg::CMD_WRITE) && !in_range) begin
                  res_status_in = dbps_pkg::STAT_RANGE;
               end
            end
         end
         dbps_pkg::ST_FETCH: ;
         dbps_pkg::ST_LOOK: begin
            res_load = 1'b1;
            if (cmd_ff == dbps_pkg::CMD_READ) res_value_in = rd_q_ff;
            else if (rd_q_ff == val_ff) res_status_in = dbps_pkg::STAT_SKIPPED;
         end
         dbps_pkg::ST_COPY: begin
            // Read word ptr of the source; write word ptr-1, taken from the registered read
            mem_raddr = dbps_pkg::bank_addr(cur_ff, ptr_ff);
            mem_we    = (ptr_ff != '0);
            if (cmd_ff == dbps_pkg::CMD_CLEAR) begin
               if (wr_word < WORD_AW'(dbps_pkg::USER_WORDS)) mem_wdata = '0;
            end else if (wr_word == idx_ff) begin
               mem_wdata = val_ff;
            end
         end
         dbps_pkg::ST_DONE: ;
         default: ;
      endcase
   end

   // Bank memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_q_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dbps_pkg::ST_CLEAR;
         clr_ptr_ff   <= '0;
         ptr_ff       <= '0;
         gen0_ff      <= '1;
         gen1_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == dbps_pkg::ST_CLEAR) clr_ptr_ff <= clr_ptr_ff + 1'b1;
         // Advance the copy pointer; hold it at zero outside the copy
         if (state_ff == dbps_pkg::ST_COPY && !copy_last) ptr_ff <= ptr_ff + 1'b1;
         else ptr_ff <= '0;
         // Promote the rewritten bank with the next generation
         if (copy_last) begin
            if (cur_ff) gen0_ff <= gen1_ff + 32'd1;
            else        gen1_ff <= gen0_ff + 32'd1;
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_ch.command;
         idx_ff <= idx_ext[WORD_AW-1:0];
         val_ff <= req_ch.write_value;
         cur_ff <= cur_bank;
      end
      if (res_load) begin
         res_value_ff  <= res_value_in;
         res_status_ff <= res_status_in;
      end
      if (rsp_load) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
         rsp_bank_ff   <= cur_bank;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.read_value   = rsp_value_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.current_bank = rsp_bank_ff;

   `DBPS_ASSERT_IMP(a_we_only_clear_or_copy, mem_we,
      state_ff == dbps_pkg::ST_CLEAR || state_ff == dbps_pkg::ST_COPY,
      "memory written outside clearing pass or copy")
   `DBPS_ASSERT_IMP(a_copy_hits_other_bank, state_ff == dbps_pkg::ST_COPY && mem_we,
      (mem_waddr >= MEM_AW'(dbps_pkg::PAGE_WORDS)) != cur_ff,
      "copy wrote into the current bank")
   `DBPS_ASSERT_NXT(a_gen_stable, !copy_last,
      $stable(gen0_ff) && $stable(gen1_ff),
      "generation changed outside copy end")
   `DBPS_ASSERT_IMP(a_value_only_on_done, rsp_ch.valid && rsp_ch.read_value != 32'd0,
      rsp_ch.status == dbps_pkg::STAT_DONE,
      "nonzero read value with a non-done status")

endmodule
`default_nettype wire

[tb/dbps_response_check.sv]
// Response checker for the dual-bank parameter store: bank image, prediction and comparison
module dbps_response_check (
   input  wire logic clock,
   input  wire logic reset,
   dbps_req_if       req_ch,
   dbps_rsp_if       rsp_ch,
   output int        pending_count,
   output int        fail_count
);
   import dbps_pkg::*;

   typedef struct packed {
      logic signed [31:0] read_value;
      status_type         status;
      logic               current_bank;
   } response_type;

   // Both banks; the last word of each holds its generation
   logic [31:0]  bank_image [2][PAGE_WORDS];
   response_type due_responses [$];

   // Bank whose generation plus one is larger as a signed word; a tie picks the second bank
   function automatic logic live_bank();
      logic signed [31:0] next0;
      logic signed [31:0] next1;
      next0 = bank_image[0][DATA_WORDS] + 32'd1;
      next1 = bank_image[1][DATA_WORDS] + 32'd1;
      return (next0 > next1) ? 1'b0 : 1'b1;
   endfunction

   // Rebuild the other bank from the live one and promote it
   function automatic void rebuild_spare(input logic wipe_user, input int slot,
                                         input logic [31:0] word);
      logic        src;
      logic        dst;
      logic [31:0] next_gen;
      int          i;
      src      = live_bank();
      dst      = ~src;
      next_gen = bank_image[src][DATA_WORDS] + 32'd1;
      for (i = 0; i < DATA_WORDS; i++) begin
         if (wipe_user)
            bank_image[dst][i] = (i < USER_WORDS) ? 32'd0 : bank_image[src][i];
         else
            bank_image[dst][i] = (i == slot) ? word : bank_image[src][i];
      end
      bank_image[dst][DATA_WORDS] = next_gen;
   endfunction

   function automatic response_type predict_response(input cmd_type command,
                                                     input logic [7:0] index,
                                                     input logic [31:0] value);
      response_type r;
      logic         bank;
      bank         = live_bank();
      r.read_value = '0;
      r.status     = STAT_DONE;
      case (command)
         CMD_READ, CMD_WRITE: begin
            if (int'(index) >= DATA_WORDS)
               r.status = STAT_RANGE;
            else if (command == CMD_READ)
               r.read_value = bank_image[bank][index];
            else if (bank_image[bank][index] == value)
               r.status = STAT_SKIPPED;
            else
               rebuild_spare(1'b0, int'(index), value);
         end
         CMD_CLEAR: rebuild_spare(1'b1, 0, '0);
         default: ;
      endcase
      r.current_bank = live_bank();
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin
      response_type seen;
      response_type want;
      int           b;
      int           w;
      if (reset) begin
         for (b = 0; b < 2; b++)
            for (w = 0; w < PAGE_WORDS; w++)
               bank_image[b][w] = '1;
         due_responses.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            due_responses.push_back(predict_response(req_ch.command, req_ch.word_index,
                                                     req_ch.write_value));
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.read_value   = rsp_ch.read_value;
            seen.status       = rsp_ch.status;
            seen.current_bank = rsp_ch.current_bank;
            if (due_responses.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = due_responses.pop_front();
               if (seen.read_value !== want.read_value)
                  report_mismatch($sformatf("read_value %h, expected %h",
                                            seen.read_value, want.read_value));
               if (seen.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            seen.status, want.status));
               if (seen.current_bank !== want.current_bank)
                  report_mismatch($sformatf("current_bank %0d, expected %0d",
                                            seen.current_bank, want.current_bank));
            end
         end
      end
      pending_count = due_responses.size();
   end

endmodule

[tb/tb_dual_bank_parameter_store.sv]
// Testbench top of the dual-bank parameter store: clock, reset, requests, back-pressure, verdict
module tb_dual_bank_parameter_store;
   import dbps_pkg::*;

   // Command code the block must ignore
   localparam cmd_type CMD_SPARE       = 2'd3;
   localparam int      RESET_CYCLES    = 12;
   localparam int      RANDOM_ITEMS    = 900;
   localparam int      PHASES          = 6;
   // Long enough to outlast several bank copies, so the block backs up into its input
   localparam int      HOLD_OFF_CYCLES = 1500;
   // Drain beyond the longest request, a changed write with its full bank copy
   localparam int      DRAIN_CYCLES    = 300;
   // Slowest correct run: 900 requests at a full copy plus the longest gap on both sides,
   // plus the clearing pass and the hold-off, taken about four times over
   localparam int      CYCLE_LIMIT     = 1_600_000;

   logic clock = 1'b0;
   logic reset;
   int   pending_count;
   int   fail_count;
   int   cycle_count = 0;
   // Set for one phase to run both sides without any idling
   bit   steady = 1'b0;
   // Raised by the request side to ask the receiver for its long hold-off
   bit   hold_off_go = 1'b0;
   logic [7:0]  last_index = 8'd0;
   logic [31:0] last_value = 32'd0;

   dbps_req_if req_ch ();
   dbps_rsp_if rsp_ch ();

   dual_bank_parameter_store dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dbps_response_check response_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap or a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady)
         return 0;
      if (r < 45)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Favour a few hot words and the boundary between user and system words,
   // so that reads and repeated writes meet values written earlier
   function automatic logic [7:0] pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return 8'($urandom_range(0, 7));
      if (r < 60)
         return 8'($urandom_range(USER_WORDS - 3, DATA_WORDS - 1));
      return 8'($urandom_range(0, DATA_WORDS - 1));
   endfunction

   // Zero and all ones often match cleared or erased words, giving unchanged writes
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom;
      if (r < 75)
         return 32'd0;
      if (r < 85)
         return 32'hFFFF_FFFF;
      if (r < 90)
         return 32'h8000_0000;
      if (r < 95)
         return 32'h7FFF_FFFF;
      return 32'($urandom_range(0, 15));
   endfunction

   // Offer one request after a random gap and hold it until the block takes it.
   // With no gap, valid simply stays high and only the payload moves on.
   task automatic send_request(input cmd_type command, input logic [7:0] index,
                               input logic [31:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= command;
      req_ch.word_index  <= index;
      req_ch.write_value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // One random request: mostly reads and writes of hot words, some repeats of the
   // last write, clears, ignored commands and indexes past the data words
   task automatic random_request();
      int          kind;
      logic [7:0]  index;
      logic [31:0] value;
      kind  = $urandom_range(0, 99);
      index = pick_index();
      value = pick_value();
      if (kind < 30) begin
         send_request(CMD_READ, index, value);
      end else if (kind < 63) begin
         last_index = index;
         last_value = value;
         send_request(CMD_WRITE, index, value);
      end else if (kind < 73) begin
         send_request(CMD_WRITE, last_index, last_value);
      end else if (kind < 80) begin
         send_request(CMD_CLEAR, 8'($urandom), $urandom);
      end else if (kind < 85) begin
         send_request(CMD_SPARE, 8'($urandom), $urandom);
      end else if (kind < 92) begin
         send_request(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_WRITE, 8'd255, value);
      end else begin
         send_request(CMD_READ, last_index, value);
      end
   endtask

   // Request side: reset, directed requests, random phases, drain and verdict
   initial begin
      int phase;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.command     <= CMD_READ;
      req_ch.word_index  <= 8'd0;
      req_ch.write_value <= 32'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Erased banks: the generations tie, so the second bank is current
      send_request(CMD_READ, 8'd0, 32'd0);
      send_request(CMD_READ, 8'(DATA_WORDS - 1), 32'd0);
      // The generation word and beyond are out of range for reads and writes
      send_request(CMD_READ, 8'd255, 32'd0);
      send_request(CMD_WRITE, 8'd255, 32'h1234_5678);
      // Writing the erased value changes nothing
      send_request(CMD_WRITE, 8'd0, 32'hFFFF_FFFF);
      // First real write promotes the first bank
      send_request(CMD_WRITE, 8'd0, 32'h8000_0000);
      send_request(CMD_READ, 8'd0, 32'd0);
      send_request(CMD_WRITE, 8'(DATA_WORDS - 1), 32'h7FFF_FFFF);
      send_request(CMD_WRITE, 8'(DATA_WORDS - 1), 32'h7FFF_FFFF);
      send_request(CMD_WRITE, 8'd128, 32'd0);
      send_request(CMD_READ, 8'(DATA_WORDS - 1), 32'd0);
      // Unused command with every payload bit set
      send_request(CMD_SPARE, 8'hFF, 32'hFFFF_FFFF);
      // Clear ignores its index and value
      send_request(CMD_CLEAR, 8'd77, 32'hDEAD_BEEF);
      send_request(CMD_READ, 8'd0, 32'd0);
      send_request(CMD_READ, 8'(DATA_WORDS - 1), 32'd0);
      send_request(CMD_WRITE, 8'd0, 32'd0);
      // Last user word and first system word, then clear across the boundary
      send_request(CMD_WRITE, 8'(USER_WORDS - 1), 32'd1);
      send_request(CMD_WRITE, 8'(USER_WORDS), 32'd2);
      send_request(CMD_CLEAR, 8'd0, 32'd0);
      send_request(CMD_READ, 8'(USER_WORDS - 1), 32'd0);
      send_request(CMD_READ, 8'(USER_WORDS), 32'd0);
      send_request(CMD_WRITE, 8'd200, 32'h5555_5555);
      send_request(CMD_WRITE, 8'd200, 32'hAAAA_AAAA);
      send_request(CMD_READ, 8'd200, 32'd0);

      // One phase without idling, one with the long hold-off on the receiver
      for (phase = 0; phase < PHASES; phase++) begin
         steady = (phase == 3);
         if (phase == 1)
            hold_off_go = 1'b1;
         repeat (RANDOM_ITEMS / PHASES) random_request();
      end
      steady = 1'b0;

      // Drop valid, wait for every outstanding response, then let the block settle
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Response side: random stalls, and once a long hold-off counted here
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // Watchdog: stop a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/dbps_pkg.sv
rtl/dbps_if.sv
rtl/dual_bank_parameter_store.sv
tb/dbps_response_check.sv
tb/tb_dual_bank_parameter_store.sv
